[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clock, outside of reset.
`define A85_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define A85_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/a85_pkg.sv]
`default_nettype none

package a85_pkg;

   localparam logic [7:0]  FirstDigit = 8'h21;
   localparam logic [7:0]  LastDigit  = 8'h75;
   localparam logic [7:0]  ZeroMark   = 8'h7A;
   localparam logic [7:0]  OnesMark   = 8'h79;
   localparam logic [31:0] Radix      = 32'd85;
   localparam logic [2:0]  LastDigitIdx = 3'd4;
   localparam logic [1:0]  LastByteIdx  = 2'd3;

   // One decoded group handed from the decoder to the byte serializer.
   typedef struct packed {
      logic        err;
      logic        last;
      logic [31:0] word;
   } a85_event_type;

endpackage

`default_nettype wire

[rtl/core/a85_group_decoder.sv]
`default_nettype none

module a85_group_decoder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_in_char,
   input  wire logic                  req_is_last,
   output logic                       ev_valid,
   output a85_pkg::a85_event_type     ev,
   input  wire logic                  ev_take
);
   import a85_pkg::*;

   `include "assert_macros.svh"

   logic [31:0]   group_ff, group_in;
   logic [2:0]    digits_ff, digits_in;
   logic          err_ff, err_in;
   logic          ev_valid_ff, ev_valid_in;
   a85_event_type ev_ff, ev_in;

   logic          accept;
   logic          at_start;
   logic          in_range;
   logic [7:0]    digit;
   logic [31:0]   acc;
   logic          have_word;
   logic [31:0]   word;
   logic          bad;
   logic          produce;

   assign req_stall = ev_valid_ff && !ev_take;
   assign accept    = req_valid && !req_stall;
   assign ev_valid  = ev_valid_ff;
   assign ev        = ev_ff;

   always_comb begin
      at_start  = (digits_ff == 3'd0);
      in_range  = (req_in_char >= FirstDigit) && (req_in_char <= LastDigit);
      digit     = req_in_char - FirstDigit;
      acc       = 32'(group_ff * Radix) + {24'd0, digit};
      group_in  = group_ff;
      digits_in = digits_ff;
      have_word = 1'b0;
      word      = 32'd0;
      bad       = err_ff;

      if (!err_ff) begin
         priority if (at_start && req_in_char == ZeroMark) begin
            have_word = 1'b1;
            word      = 32'd0;
         end else if (at_start && req_in_char == OnesMark) begin
            have_word = 1'b1;
            word      = '1;
         end else if (!in_range) begin
            bad = 1'b1;
         end else if (digits_ff == LastDigitIdx) begin
            have_word = 1'b1;
            word      = acc;
            group_in  = 32'd0;
            digits_in = 3'd0;
         end else begin
            group_in  = acc;
            digits_in = digits_ff + 3'd1;
         end
      end

      // The final character always yields a result and restarts the string.
      if (req_is_last) begin
         if (digits_in != 3'd0) begin
            bad = 1'b1;
         end
         produce   = 1'b1;
         group_in  = 32'd0;
         digits_in = 3'd0;
         err_in    = 1'b0;
      end else begin
         produce = have_word;
         err_in  = bad;
      end

      ev_in.err  = req_is_last && bad;
      ev_in.last = req_is_last;
      ev_in.word = (req_is_last && bad) ? 32'd0 : word;

      if (accept && produce) begin
         ev_valid_in = 1'b1;
      end else if (ev_take) begin
         ev_valid_in = 1'b0;
      end else begin
         ev_valid_in = ev_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff    <= 32'd0;
         digits_ff   <= 3'd0;
         err_ff      <= 1'b0;
         ev_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            group_ff  <= group_in;
            digits_ff <= digits_in;
            err_ff    <= err_in;
         end
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         ev_ff <= ev_in;
      end
   end

   `A85_ASSERT(digits_bounded, digits_ff <= LastDigitIdx, "group digit count above four")
   `A85_ASSERT_NEXT(event_held, ev_valid_ff && !ev_take,
      ev_valid_ff && $stable(ev_ff), "pending group changed before transfer")
   `A85_ASSERT_NEXT(string_restart, accept && req_is_last,
      digits_ff == 3'd0 && !err_ff && group_ff == 32'd0, "state not cleared after last item")

endmodule

`default_nettype wire

[rtl/core/a85_byte_serializer.sv]
`default_nettype none

module a85_byte_serializer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  ev_valid,
   input  wire a85_pkg::a85_event_type ev,
   output logic                       ev_take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_run_end,
   output logic                       rsp_bad_input,
   output logic                       rsp_string_end
);
   import a85_pkg::*;

   `include "assert_macros.svh"

   logic        valid_ff, valid_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic        err_ff, err_in;
   logic        last_ff, last_in;

   logic        transfer;
   logic        run_end;

   assign transfer = valid_ff && !rsp_stall;
   assign run_end  = err_ff || (cnt_ff == LastByteIdx);
   assign ev_take  = ev_valid && (!valid_ff || (transfer && run_end));

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      word_in  = word_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      if (ev_take) begin
         valid_in = 1'b1;
         cnt_in   = 2'd0;
         word_in  = ev.word;
         err_in   = ev.err;
         last_in  = ev.last;
      end else if (transfer) begin
         // Bytes leave most significant first, so the word shifts up.
         valid_in = !run_end;
         cnt_in   = cnt_ff + 2'd1;
         word_in  = {word_ff[23:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = word_ff[31:24];
   assign rsp_run_end    = run_end;
   assign rsp_bad_input  = err_ff;
   assign rsp_string_end = last_ff;

   `A85_ASSERT(error_result_alone, !(valid_ff && err_ff) || (cnt_ff == 2'd0 &&
      rsp_out_byte == 8'h00), "error result is not a lone zero result")
   `A85_ASSERT_NEXT(byte_advance, transfer && !run_end,
      valid_ff && cnt_ff == $past(cnt_ff) + 2'd1, "byte index did not advance")
   `A85_ASSERT_NEXT(result_held, valid_ff && rsp_stall,
      valid_ff && $stable(word_ff) && $stable(cnt_ff), "stalled result changed")

endmodule

`default_nettype wire

[rtl/core/ascii85_stream_decoder.sv]
`default_nettype none

// Ascii85 stream decoder: one character enters per transfer on req_, and each
// completed group leaves as four byte transfers on rsp_, most significant byte
// first ('z' gives four zero bytes, 'y' four 0xFF bytes). Characters are taken
// one per cycle while no completed group waits in the decoder; a waiting group
// stalls req_ until the byte serializer, which drives the single result port
// and is held by rsp_stall, can take it. A bad string gives one result with
// bad_input set on its last character; bytes already sent for that string must
// be dropped. A completed group passes through the decoder's event register
// and then the serializer's word register before its bytes appear on rsp_.
module ascii85_stream_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_end,
   output logic            rsp_bad_input,
   output logic            rsp_string_end
);
   import a85_pkg::*;

   logic          ev_valid;
   logic          ev_take;
   a85_event_type ev;

   a85_group_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .req_is_last (req_is_last),
      .ev_valid    (ev_valid),
      .ev          (ev),
      .ev_take     (ev_take)
   );

   a85_byte_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .ev_valid       (ev_valid),
      .ev             (ev),
      .ev_take        (ev_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_bad_input  (rsp_bad_input),
      .rsp_string_end (rsp_string_end)
   );

endmodule

`default_nettype wire

[tb/tb_ascii85_stream_decoder.sv]
`default_nettype none

module tb_ascii85_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import a85_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       bad_input;
      logic       string_end;
   } byte_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_end;
   logic       rsp_bad_input;
   logic       rsp_string_end;

   // Decoder state kept alongside the block.
   logic [31:0] group_acc = '0;
   logic [2:0]  digit_count = '0;
   logic        string_bad = 1'b0;

   byte_result_type expected_bytes[$];

   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   int chars_sent = 0;
   int bytes_checked = 0;
   int bad_results = 0;
   int strings_sent = 0;
   int error_count = 0;

   ascii85_stream_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_char    (req_in_char),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_bad_input  (rsp_bad_input),
      .rsp_string_end (rsp_string_end)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   // Works out the bytes that one accepted character produces.
   task automatic decode_char(input logic [7:0] ch, input logic last);
      logic            have_word;
      logic [31:0]     word;
      byte_result_type res;
      have_word = 1'b0;
      word = '0;
      if (!string_bad) begin
         if (digit_count == 3'd0 && ch == ZeroMark) begin
            have_word = 1'b1;
            word = 32'h0000_0000;
         end else if (digit_count == 3'd0 && ch == OnesMark) begin
            have_word = 1'b1;
            word = 32'hFFFF_FFFF;
         end else if (ch < FirstDigit || ch > LastDigit) begin
            string_bad = 1'b1;
         end else begin
            group_acc = group_acc * Radix + {24'h0, ch - FirstDigit};
            digit_count = digit_count + 3'd1;
            if (digit_count == 3'd5) begin
               have_word = 1'b1;
               word = group_acc;
               group_acc = '0;
               digit_count = '0;
            end
         end
      end
      if (last && digit_count != 3'd0)
         string_bad = 1'b1;
      if (last && string_bad) begin
         res = '{out_byte: 8'h00, run_end: 1'b1, bad_input: 1'b1, string_end: 1'b1};
         expected_bytes.push_back(res);
      end else if (have_word) begin
         for (int k = 0; k < 4; k++) begin
            res.out_byte = word[31 - 8 * k -: 8];
            res.run_end = (k == 3);
            res.bad_input = 1'b0;
            res.string_end = last;
            expected_bytes.push_back(res);
         end
      end
      if (last) begin
         group_acc = '0;
         digit_count = '0;
         string_bad = 1'b0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_char(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid = 1'b0;
         req_in_char = 8'($urandom);
         req_is_last = 1'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_char = ch;
      req_is_last = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_char(ch, last);
      chars_sent++;
      if (last) strings_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         byte_result_type got;
         byte_result_type exp;
         got = '{rsp_out_byte, rsp_run_end, rsp_bad_input, rsp_string_end};
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected result byte=%h run_end=%b bad=%b str_end=%b",
                     $time, got.out_byte, got.run_end, got.bad_input, got.string_end);
            error_count++;
         end else begin
            exp = expected_bytes.pop_front();
            if (got !== exp) begin
               $display("%0t: mismatch expected byte=%h run_end=%b bad=%b str_end=%b",
                        $time, exp.out_byte, exp.run_end, exp.bad_input, exp.string_end);
               $display("%0t:          actual   byte=%h run_end=%b bad=%b str_end=%b",
                        $time, got.out_byte, got.run_end, got.bad_input, got.string_end);
               error_count++;
            end
            bytes_checked++;
            if (exp.bad_input) bad_results++;
         end
      end
   end

   // Smallest and largest groups, wrap-around, and both shorthand characters.
   task automatic test_groups_and_shorthand();
      send_text("!!!!!");
      send_text("uuuuu");
      send_char(ZeroMark, 1'b0);
      send_char(OnesMark, 1'b0);
      send_char(OnesMark, 1'b1);
      send_char(ZeroMark, 1'b1);
   endtask

   // Bad characters, shorthand inside a group, sticky errors and truncation.
   task automatic test_error_cases();
      send_char(FirstDigit, 1'b0);
      send_char(ZeroMark, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(FirstDigit, 1'b1);
      send_char(8'h00, 1'b1);
      send_char(FirstDigit, 1'b0);
      send_char(LastDigit, 1'b1);
      send_char(FirstDigit, 1'b0);
      send_char(OnesMark, 1'b1);
      send_char(8'h20, 1'b0);
      send_char(ZeroMark, 1'b1);
      send_char(8'h76, 1'b1);
      send_char(8'h80, 1'b1);
   endtask

   task automatic send_random_string();
      logic [7:0] text[$];
      int n_groups;
      int pick;
      n_groups = $urandom_range(1, 4);
      for (int g = 0; g < n_groups; g++) begin
         pick = $urandom_range(0, 5);
         if (pick == 0) begin
            text.push_back(ZeroMark);
         end else if (pick == 1) begin
            text.push_back(OnesMark);
         end else begin
            for (int d = 0; d < 5; d++) begin
               pick = $urandom_range(0, 9);
               if (pick == 0) text.push_back(FirstDigit);
               else if (pick == 1) text.push_back(LastDigit);
               else text.push_back(8'($urandom_range(FirstDigit, LastDigit)));
            end
         end
      end
      // A minority of strings are damaged or left with an open group.
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(1) == 0) begin
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
         end else begin
            pick = $urandom_range(1, 4);
            for (int d = 0; d < pick; d++)
               text.push_back(8'($urandom_range(FirstDigit, LastDigit)));
         end
      end
      foreach (text[i])
         send_char(text[i], i == text.size() - 1);
   endtask

   task automatic test_random_strings(input int idle_pct, input int stall_pct);
      int start_count;
      src_idle_pct = idle_pct;
      sink_stall_pct = stall_pct;
      start_count = chars_sent;
      while (chars_sent - start_count < 50)
         send_random_string();
      wait_drained();
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_groups_and_shorthand();
      test_error_cases();
      wait_drained();
      test_random_strings(0, 0);
      test_random_strings(87, 0);
      test_random_strings(0, 87);
      test_random_strings(26, 26);
      wait_drained();
      repeat (20) @(negedge clock);
      $display("Sent %0d characters in %0d strings; checked %0d results, %0d of them bad-string.",
               chars_sent, strings_sent, bytes_checked, bad_results);
      $display("Ran with no idling, sender gaps, receiver stalls and both mixed.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/a85_pkg.sv
rtl/core/a85_group_decoder.sv
rtl/core/a85_byte_serializer.sv
rtl/core/ascii85_stream_decoder.sv
tb/tb_ascii85_stream_decoder.sv
